FILE: rtl/rsi_pkg.sv
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int COORD_FRAC_BITS = 16;

  // field widths
  localparam int CW  = 32;
  localparam int RCW = 18;
  localparam int FW  = 31;

  // datapath widths
  localparam int DW        = CW + 1;
  localparam int PW        = DW + RCW;
  localparam int SW        = PW + 1;
  localparam int UW        = SW + 1;
  localparam int ROT_SHIFT = 16;
  localparam int LOW_W     = 27;
  localparam int HI_W      = UW - LOW_W;
  localparam int NW        = DW + UW + 1;
  localparam int AW        = NW + COORD_FRAC_BITS;
  localparam int SNW       = 2 * UW + 1;
  localparam int SPW       = SNW + 1;
  localparam int RW        = NW + FW + 1;

  localparam int NST        = FW + 1;
  localparam int FST        = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int NORM_LIMIT = 65536;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [2:0] REG_EDGE_START_X = 3'd0;
  localparam logic [2:0] REG_EDGE_START_Y = 3'd1;
  localparam logic [2:0] REG_EDGE_END_X   = 3'd2;
  localparam logic [2:0] REG_EDGE_END_Y   = 3'd3;
  localparam logic [2:0] REG_OFFSET_X     = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y     = 3'd5;
  localparam logic [2:0] REG_ROT_COS      = 3'd6;
  localparam logic [2:0] REG_ROT_SIN      = 3'd7;

  typedef struct packed {
    logic [CW-1:0]  edge_start_x;
    logic [CW-1:0]  edge_start_y;
    logic [CW-1:0]  edge_end_x;
    logic [CW-1:0]  edge_end_y;
    logic [CW-1:0]  offset_x;
    logic [CW-1:0]  offset_y;
    logic [RCW-1:0] rot_cos;
    logic [RCW-1:0] rot_sin;
  } cfg_t;

  typedef struct packed {
    logic          miss;
    logic          flip;
    logic [AW-1:0] a;
    logic [NW-1:0] b;
    logic [FW-1:0] maxf;
  } ent_t;

  typedef struct packed {
    logic           busy;
    logic [RCW-1:0] wxp;
    logic [RCW-1:0] wxn;
    logic [RCW-1:0] wyp;
    logic [RCW-1:0] wyn;
  } nrm_t;

endpackage

FILE: rtl/rsi_normal.sv
`timescale 1ns / 1ps
module rsi_normal import rsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic restart_i,
  output nrm_t nrm_o
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_SHR  = 4'd1;
  localparam logic [3:0] S_ZCHK = 4'd2;
  localparam logic [3:0] S_SHL  = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DIVI = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_SIGN = 4'd9;
  localparam logic [3:0] S_ROT  = 4'd10;
  localparam logic [3:0] S_RND  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  localparam int MW  = 31;
  localparam int LW  = 32;
  localparam int DVW = MW + 17;
  localparam int VW  = 2 * RCW + 2;
  localparam int WW  = VW - 16;

  logic [3:0] st_q;
  logic signed [DW-1:0] ex, ey;
  logic signed [RCW-1:0] rc, rs;
  logic [DW-1:0] mx_q, my_q, orv;
  logic [2*MW-1:0] sqx_q, sqy_q;
  logic [63:0] x_q, res_q, bit_q, sqt;
  logic [DVW-1:0] dvx_q, dvy_q;
  logic [LW-1:0] rx_q, ry_q, len;
  logic [LW:0] tx, ty;
  logic [RCW-1:0] qx_q, qy_q;
  logic [5:0] cnt_q;
  logic signed [RCW-1:0] nx_q, ny_q;
  logic signed [2*RCW-1:0] cnx_q, sny_q, snx_q, cny_q;
  logic signed [VW-1:0] vx, vy;
  logic signed [WW-1:0] wx, wy;
  logic [RCW-1:0] wxp_q, wxn_q, wyp_q, wyn_q;

  function automatic logic [RCW-1:0] clampn(input logic signed [WW:0] v);
    if (v > (WW+1)'(NORM_LIMIT)) return RCW'(NORM_LIMIT);
    else if (v < (WW+1)'(-NORM_LIMIT)) return RCW'(-NORM_LIMIT);
    else return v[RCW-1:0];
  endfunction

  assign ex  = DW'($signed(cfg_i.edge_end_x)) - DW'($signed(cfg_i.edge_start_x));
  assign ey  = DW'($signed(cfg_i.edge_end_y)) - DW'($signed(cfg_i.edge_start_y));
  assign rc  = cfg_i.rot_cos;
  assign rs  = cfg_i.rot_sin;
  assign orv = mx_q | my_q;
  assign len = res_q[LW-1:0];
  assign sqt = res_q + bit_q;
  assign tx  = {rx_q, dvx_q[DVW-1]};
  assign ty  = {ry_q, dvy_q[DVW-1]};
  // round half up: floor((v + half) / 2^16)
  assign vx  = VW'(cnx_q) - VW'(sny_q) + VW'(32768);
  assign vy  = VW'(snx_q) + VW'(cny_q) + VW'(32768);
  assign wx  = vx[VW-1:16];
  assign wy  = vy[VW-1:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD;
    end else if (restart_i) begin
      st_q <= S_LOAD;
    end else begin
      case (st_q)
        S_LOAD: st_q <= S_SHR;
        S_SHR:  if (orv[DW-1:MW] == '0) st_q <= S_ZCHK;
        S_ZCHK: st_q <= (orv == '0) ? S_ROT : S_SHL;
        S_SHL:  if (orv[MW-1]) st_q <= S_SQ;
        S_SQ:   st_q <= S_SUM;
        S_SUM:  st_q <= S_SQRT;
        S_SQRT: if (bit_q == '0) st_q <= S_DIVI;
        S_DIVI: st_q <= S_DIV;
        S_DIV:  if (cnt_q == 6'(DVW - 1)) st_q <= S_SIGN;
        S_SIGN: st_q <= S_ROT;
        S_ROT:  st_q <= S_RND;
        S_RND:  st_q <= S_DONE;
        S_DONE: st_q <= S_DONE;
        default: st_q <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_LOAD: begin
        mx_q <= ey[DW-1] ? DW'(-ey) : DW'(ey);
        my_q <= ex[DW-1] ? DW'(-ex) : DW'(ex);
        nx_q <= '0;
        ny_q <= '0;
      end
      S_SHR: begin
        if (orv[DW-1:MW] != '0) begin
          mx_q <= mx_q >> 1;
          my_q <= my_q >> 1;
        end
      end
      S_SHL: begin
        if (!orv[MW-1]) begin
          mx_q <= mx_q << 1;
          my_q <= my_q << 1;
        end
      end
      S_SQ: begin
        sqx_q <= mx_q[MW-1:0] * mx_q[MW-1:0];
        sqy_q <= my_q[MW-1:0] * my_q[MW-1:0];
      end
      S_SUM: begin
        x_q   <= 64'(sqx_q) + 64'(sqy_q);
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      S_SQRT: begin
        if (bit_q != '0) begin
          if (x_q >= sqt) begin
            x_q   <= x_q - sqt;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      S_DIVI: begin
        dvx_q <= (DVW'(mx_q[MW-1:0]) << 16) + DVW'(len >> 1);
        dvy_q <= (DVW'(my_q[MW-1:0]) << 16) + DVW'(len >> 1);
        rx_q  <= '0;
        ry_q  <= '0;
        qx_q  <= '0;
        qy_q  <= '0;
        cnt_q <= '0;
      end
      S_DIV: begin
        dvx_q <= dvx_q << 1;
        dvy_q <= dvy_q << 1;
        cnt_q <= cnt_q + 6'd1;
        if (tx >= {1'b0, len}) begin
          rx_q <= LW'(tx - {1'b0, len});
          qx_q <= {qx_q[RCW-2:0], 1'b1};
        end else begin
          rx_q <= tx[LW-1:0];
          qx_q <= {qx_q[RCW-2:0], 1'b0};
        end
        if (ty >= {1'b0, len}) begin
          ry_q <= LW'(ty - {1'b0, len});
          qy_q <= {qy_q[RCW-2:0], 1'b1};
        end else begin
          ry_q <= ty[LW-1:0];
          qy_q <= {qy_q[RCW-2:0], 1'b0};
        end
      end
      S_SIGN: begin
        nx_q <= ey[DW-1] ? -$signed(qx_q) : $signed(qx_q);
        ny_q <= (!ex[DW-1] && ex != '0) ? -$signed(qy_q) : $signed(qy_q);
      end
      S_ROT: begin
        cnx_q <= rc * nx_q;
        sny_q <= rs * ny_q;
        snx_q <= rs * nx_q;
        cny_q <= rc * ny_q;
      end
      S_RND: begin
        wxp_q <= clampn((WW+1)'(wx));
        wxn_q <= clampn(-(WW+1)'(wx));
        wyp_q <= clampn((WW+1)'(wy));
        wyn_q <= clampn(-(WW+1)'(wy));
      end
      default: ;
    endcase
  end

  assign nrm_o.busy = (st_q != S_DONE);
  assign nrm_o.wxp  = wxp_q;
  assign nrm_o.wxn  = wxn_q;
  assign nrm_o.wyp  = wyp_q;
  assign nrm_o.wyn  = wyn_q;

endmodule

FILE: rtl/rsi_front.sv
`timescale 1ns / 1ps
module rsi_front import rsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 adv_i,
  input  logic                 take_i,
  input  logic signed [CW-1:0] start_x_i,
  input  logic signed [CW-1:0] start_y_i,
  input  logic signed [CW-1:0] end_x_i,
  input  logic signed [CW-1:0] end_y_i,
  input  logic [FW-1:0]        max_fraction_i,
  output logic                 push_o,
  output ent_t                 ent_o
);

  localparam int PAH = DW + HI_W;
  localparam int PAL = DW + LOW_W + 1;
  localparam int PHH = 2 * HI_W;
  localparam int PHL = HI_W + LOW_W + 1;
  localparam int PLL = 2 * LOW_W + 2;

  logic [FST-1:0] vld_q;

  logic signed [RCW-1:0] rc, rs;
  logic signed [CW-1:0] v1x, v1y, ox, oy, v2x, v2y;
  logic signed [DW-1:0] ex, ey;
  logic signed [UW-1:0] sv1x, sv1y;

  logic signed [DW-1:0] ax1_q, ay1_q, bx1_q, by1_q;
  logic [FW-1:0] mf_q [FST];
  logic signed [PW-1:0] cax2_q, say2_q, cay2_q, sax2_q, cbx2_q, sby2_q, cby2_q, sbx2_q;
  logic signed [SW-1:0] p1x3_q, p1y3_q, p2x3_q, p2y3_q;
  logic signed [UW-1:0] ux4_q, uy4_q, dx4_q, dy4_q;
  logic signed [HI_W-1:0] uxh, uyh, dxh, dyh;
  logic signed [LOW_W:0] uxl, uyl, dxl, dyl;
  logic signed [PAH-1:0] pah5_q, pbh5_q, pch5_q, pdh5_q;
  logic signed [PAL-1:0] pal5_q, pbl5_q, pcl5_q, pdl5_q;
  logic signed [PHH-1:0] ehh5_q, fhh5_q;
  logic signed [PHL-1:0] ehl5_q, elh5_q, fhl5_q, flh5_q;
  logic signed [PLL-1:0] ell5_q, fll5_q;
  logic signed [NW-1:0] a6_q, b6_q, c6_q, d6_q;
  logic signed [SNW-1:0] e6_q, f6_q;
  logic signed [NW-1:0] num7_q, den7_q;
  logic signed [SNW-1:0] sn7_q;
  logic [NW-1:0] anum8_q, aden8_q;
  logic signed [SPW-1:0] snp8_q;
  logic dz8_q, mism8_q, flip8_q;
  logic seg_bad;

  assign rc   = cfg_i.rot_cos;
  assign rs   = cfg_i.rot_sin;
  assign v1x  = cfg_i.edge_start_x;
  assign v1y  = cfg_i.edge_start_y;
  assign v2x  = cfg_i.edge_end_x;
  assign v2y  = cfg_i.edge_end_y;
  assign ox   = cfg_i.offset_x;
  assign oy   = cfg_i.offset_y;
  assign ex   = DW'(v2x) - DW'(v1x);
  assign ey   = DW'(v2y) - DW'(v1y);
  assign sv1x = UW'(v1x) <<< ROT_SHIFT;
  assign sv1y = UW'(v1y) <<< ROT_SHIFT;

  // split the wide operands into a signed high part and an unsigned low part
  assign uxh = ux4_q[UW-1:LOW_W];
  assign uyh = uy4_q[UW-1:LOW_W];
  assign dxh = dx4_q[UW-1:LOW_W];
  assign dyh = dy4_q[UW-1:LOW_W];
  assign uxl = {1'b0, ux4_q[LOW_W-1:0]};
  assign uyl = {1'b0, uy4_q[LOW_W-1:0]};
  assign dxl = {1'b0, dx4_q[LOW_W-1:0]};
  assign dyl = {1'b0, dy4_q[LOW_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[FST-2:0], take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ax1_q <= DW'(start_x_i) - DW'(ox);
      ay1_q <= DW'(start_y_i) - DW'(oy);
      bx1_q <= DW'(end_x_i) - DW'(ox);
      by1_q <= DW'(end_y_i) - DW'(oy);
      mf_q[0] <= max_fraction_i;
      for (int j = 1; j < FST; j++) mf_q[j] <= mf_q[j-1];

      cax2_q <= rc * ax1_q;
      say2_q <= rs * ay1_q;
      cay2_q <= rc * ay1_q;
      sax2_q <= rs * ax1_q;
      cbx2_q <= rc * bx1_q;
      sby2_q <= rs * by1_q;
      cby2_q <= rc * by1_q;
      sbx2_q <= rs * bx1_q;

      p1x3_q <= SW'(cax2_q) + SW'(say2_q);
      p1y3_q <= SW'(cay2_q) - SW'(sax2_q);
      p2x3_q <= SW'(cbx2_q) + SW'(sby2_q);
      p2y3_q <= SW'(cby2_q) - SW'(sbx2_q);

      dx4_q <= UW'(p2x3_q) - UW'(p1x3_q);
      dy4_q <= UW'(p2y3_q) - UW'(p1y3_q);
      ux4_q <= sv1x - UW'(p1x3_q);
      uy4_q <= sv1y - UW'(p1y3_q);

      pah5_q <= ey * uxh;
      pal5_q <= ey * uxl;
      pbh5_q <= ex * uyh;
      pbl5_q <= ex * uyl;
      pch5_q <= ey * dxh;
      pcl5_q <= ey * dxl;
      pdh5_q <= ex * dyh;
      pdl5_q <= ex * dyl;
      ehh5_q <= uyh * dxh;
      ehl5_q <= uyh * dxl;
      elh5_q <= uyl * dxh;
      ell5_q <= uyl * dxl;
      fhh5_q <= uxh * dyh;
      fhl5_q <= uxh * dyl;
      flh5_q <= uxl * dyh;
      fll5_q <= uxl * dyl;

      a6_q <= (NW'(pah5_q) <<< LOW_W) + NW'(pal5_q);
      b6_q <= (NW'(pbh5_q) <<< LOW_W) + NW'(pbl5_q);
      c6_q <= (NW'(pch5_q) <<< LOW_W) + NW'(pcl5_q);
      d6_q <= (NW'(pdh5_q) <<< LOW_W) + NW'(pdl5_q);
      e6_q <= (SNW'(ehh5_q) <<< (2 * LOW_W)) + (SNW'(ehl5_q) <<< LOW_W)
            + (SNW'(elh5_q) <<< LOW_W) + SNW'(ell5_q);
      f6_q <= (SNW'(fhh5_q) <<< (2 * LOW_W)) + (SNW'(fhl5_q) <<< LOW_W)
            + (SNW'(flh5_q) <<< LOW_W) + SNW'(fll5_q);

      num7_q <= a6_q - b6_q;
      den7_q <= c6_q - d6_q;
      sn7_q  <= e6_q - f6_q;

      anum8_q <= num7_q[NW-1] ? NW'(-num7_q) : NW'(num7_q);
      aden8_q <= den7_q[NW-1] ? NW'(-den7_q) : NW'(den7_q);
      // segment cross product, negated when the denominator is positive
      snp8_q  <= (!den7_q[NW-1] && den7_q != '0) ? -SPW'(sn7_q) : SPW'(sn7_q);
      dz8_q   <= (den7_q == '0);
      mism8_q <= (num7_q != '0) && (num7_q[NW-1] != den7_q[NW-1]);
      flip8_q <= !num7_q[NW-1] && (num7_q != '0);
    end
  end

  assign seg_bad = snp8_q[SPW-1] || (snp8_q > $signed(SPW'(aden8_q) << ROT_SHIFT));

  assign push_o     = adv_i & vld_q[FST-1];
  assign ent_o.miss = dz8_q | mism8_q | seg_bad;
  assign ent_o.flip = flip8_q;
  assign ent_o.a    = AW'(anum8_q) << COORD_FRAC_BITS;
  assign ent_o.b    = aden8_q;
  assign ent_o.maxf = mf_q[FST-1];

endmodule

FILE: rtl/rsi_fifo.sv
`timescale 1ns / 1ps
module rsi_fifo import rsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ent_t ent_i,
  input  logic pop_i,
  output ent_t ent_o,
  output logic full_o,
  output logic avail_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  ent_t mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= ent_i;
  end

  assign ent_o   = mem_q[rd_q];
  assign full_o  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign avail_o = (cnt_q != '0);

endmodule

FILE: rtl/rsi_back.sv
`timescale 1ns / 1ps
module rsi_back import rsi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ent_t                  ent_i,
  input  logic                  avail_i,
  input  nrm_t                  nrm_i,
  input  logic                  out_ready_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  output logic                  hit_o,
  output logic [FW-1:0]         fraction_o,
  output logic signed [RCW-1:0] normal_x_o,
  output logic signed [RCW-1:0] normal_y_o
);

  logic en;
  logic [NST-1:0] sv_q, miss_q, flip_q, miss_d;
  logic [RW-1:0] rem_q [NST];
  logic [RW-1:0] rem_d [NST];
  logic [RW-1:0] bk [NST];
  logic [NW-1:0] b_q [NST];
  logic [FW-1:0] q_q [NST];
  logic [FW-1:0] q_d [NST];
  logic [FW-1:0] mf_q [NST];
  logic fmiss;
  logic out_vld_q, hit_q;
  logic [FW-1:0] frac_q;
  logic [RCW-1:0] nx_q, ny_q;

  assign en    = !out_vld_q || out_ready_i;
  assign pop_o = en && avail_i;

  // one quotient bit per stage after the first, most significant first
  always_comb begin
    bk[0]     = RW'(ent_i.b) << FW;
    rem_d[0]  = RW'(ent_i.a);
    q_d[0]    = '0;
    miss_d[0] = ent_i.miss || (rem_d[0] >= bk[0]);
    for (int j = 1; j < NST; j++) begin
      bk[j]     = RW'(b_q[j-1]) << (FW - j);
      miss_d[j] = miss_q[j-1];
      if (rem_q[j-1] >= bk[j]) begin
        rem_d[j] = rem_q[j-1] - bk[j];
        q_d[j]   = q_q[j-1] | (FW'(1) << (FW - j));
      end else begin
        rem_d[j] = rem_q[j-1];
        q_d[j]   = q_q[j-1];
      end
    end
  end

  assign fmiss = miss_q[NST-1] || (q_q[NST-1] > mf_q[NST-1])
              || ((q_q[NST-1] == mf_q[NST-1]) && (rem_q[NST-1] != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      sv_q      <= {sv_q[NST-2:0], pop_o};
      out_vld_q <= sv_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q[0]  <= ent_i.b;
      mf_q[0] <= ent_i.maxf;
      flip_q  <= {flip_q[NST-2:0], ent_i.flip};
      miss_q  <= miss_d;
      for (int j = 0; j < NST; j++) begin
        rem_q[j] <= rem_d[j];
        q_q[j]   <= q_d[j];
      end
      for (int j = 1; j < NST; j++) begin
        b_q[j]  <= b_q[j-1];
        mf_q[j] <= mf_q[j-1];
      end
      hit_q  <= !fmiss;
      frac_q <= fmiss ? '0 : q_q[NST-1];
      nx_q   <= fmiss ? '0 : (flip_q[NST-1] ? nrm_i.wxn : nrm_i.wxp);
      ny_q   <= fmiss ? '0 : (flip_q[NST-1] ? nrm_i.wyn : nrm_i.wyp);
    end
  end

  assign out_valid_o = out_vld_q;
  assign hit_o       = hit_q;
  assign fraction_o  = frac_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;

endmodule

FILE: rtl/ray_segment_intersection_core.sv
`timescale 1ns / 1ps
// a 4-entry queue between front and divider lets the front run ahead of the divider
// throughput: one ray per cycle unless the queue is full or the normal unit is busy
// the edge normal is solved by a serial sqrt/divide unit after reset and after every
// register write; no ray is taken while it runs
// reset: asynchronous active low, registers go to an identity transform, unit x edge
module ray_segment_intersection_core import rsi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [CW-1:0]  start_x_i,
  input  logic signed [CW-1:0]  start_y_i,
  input  logic signed [CW-1:0]  end_x_i,
  input  logic signed [CW-1:0]  end_y_i,
  input  logic [FW-1:0]         max_fraction_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output logic [FW-1:0]         fraction_o,
  output logic signed [RCW-1:0] normal_x_o,
  output logic signed [RCW-1:0] normal_y_o
);

  cfg_t cfg_q;
  nrm_t nrm;
  ent_t push_ent, pop_ent;
  logic wr, take, push, pop, full, avail;
  logic [2:0] idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[APB_AW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edge_start_x <= '0;
      cfg_q.edge_start_y <= '0;
      cfg_q.edge_end_x   <= CW'(65536);
      cfg_q.edge_end_y   <= '0;
      cfg_q.offset_x     <= '0;
      cfg_q.offset_y     <= '0;
      cfg_q.rot_cos      <= RCW'(65536);
      cfg_q.rot_sin      <= '0;
    end else if (wr) begin
      case (idx)
        REG_EDGE_START_X: cfg_q.edge_start_x <= pwdata;
        REG_EDGE_START_Y: cfg_q.edge_start_y <= pwdata;
        REG_EDGE_END_X:   cfg_q.edge_end_x   <= pwdata;
        REG_EDGE_END_Y:   cfg_q.edge_end_y   <= pwdata;
        REG_OFFSET_X:     cfg_q.offset_x     <= pwdata;
        REG_OFFSET_Y:     cfg_q.offset_y     <= pwdata;
        REG_ROT_COS:      cfg_q.rot_cos      <= pwdata[RCW-1:0];
        REG_ROT_SIN:      cfg_q.rot_sin      <= pwdata[RCW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EDGE_START_X: prdata = cfg_q.edge_start_x;
      REG_EDGE_START_Y: prdata = cfg_q.edge_start_y;
      REG_EDGE_END_X:   prdata = cfg_q.edge_end_x;
      REG_EDGE_END_Y:   prdata = cfg_q.edge_end_y;
      REG_OFFSET_X:     prdata = cfg_q.offset_x;
      REG_OFFSET_Y:     prdata = cfg_q.offset_y;
      REG_ROT_COS:      prdata = APB_DW'($signed(cfg_q.rot_cos));
      REG_ROT_SIN:      prdata = APB_DW'($signed(cfg_q.rot_sin));
      default:          prdata = '0;
    endcase
  end

  assign in_ready_o = !full && !nrm.busy;
  assign take       = in_valid_i && in_ready_o;

  rsi_normal u_normal (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .restart_i (wr),
    .nrm_o     (nrm)
  );

  rsi_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .adv_i          (!full),
    .take_i         (take),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .max_fraction_i (max_fraction_i),
    .push_o         (push),
    .ent_o          (push_ent)
  );

  rsi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (push_ent),
    .pop_i   (pop),
    .ent_o   (pop_ent),
    .full_o  (full),
    .avail_o (avail)
  );

  rsi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (pop_ent),
    .avail_i     (avail),
    .nrm_i       (nrm),
    .out_ready_i (out_ready_i),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .hit_o       (hit_o),
    .fraction_o  (fraction_o),
    .normal_x_o  (normal_x_o),
    .normal_y_o  (normal_y_o)
  );

  // a miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> fraction_o == '0 && normal_x_o == '0 && normal_y_o == '0)
    else $error("miss with nonzero payload");

  // normal stays inside the clamp range
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> normal_x_o <= RCW'(NORM_LIMIT) && normal_x_o >= RCW'(-NORM_LIMIT)
      && normal_y_o <= RCW'(NORM_LIMIT) && normal_y_o >= RCW'(-NORM_LIMIT))
    else $error("normal out of range");

  // a register write restarts the normal unit, so no ray is taken right after
  a_wr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |=> !in_ready_o)
    else $error("ray taken during normal recompute");

  // a full queue with no pop is still full afterwards or takes no push
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !pop |=> full || !push)
    else $error("queue overflow");

endmodule
